// ===== design/gsll_pkg.sv =====
// ----------------------------------------------------------------------------
// gsll_pkg: shared types, constants and table functions
// Holds the queue item type that passes from the front end to the back end,
// the fixed-point constants, and the functions that build the log-add table.
// ----------------------------------------------------------------------------
package gsll_pkg;

  // Parameter defaults for the top level.
  localparam int MaxDimsDefault         = 64;
  localparam int LogTableEntriesDefault = 256;

  // Dimension counter width, sized for the largest supported MAX_DIMS.
  localparam int DimW = 11;

  // Depth of the queue between the front end and the back end.
  localparam int QueueDepth = 2;

  // Fraction bits produced by the log2 squaring loop.
  localparam int LogFracBits = 16;

  // Log-add index: difference in Q16.16 scaled by entries over a 16.0 range.
  localparam int LogaddShift = 20;

  localparam logic [16:0] LogTwoPiQ16    = 17'd120447;
  localparam logic [31:0] Ln2Q32         = 32'd2977044472;
  localparam logic [63:0] LogaddRangeQ16 = 64'd1048576;
  localparam logic [47:0] PowerMax       = '1;
  localparam logic [63:0] OneQ31         = 64'h0000_0000_8000_0000;
  localparam logic [63:0] HalfQ31        = 64'h0000_0000_4000_0000;

  // What an item does once its dimension has been accumulated.
  typedef enum logic [1:0] {
    KIND_DIM,
    KIND_COMP_END,
    KIND_STATE_END
  } kind_t;

  // One classified item as queued for the back end.
  typedef struct packed {
    kind_t              kind;
    logic               acc;
    logic [DimW-1:0]    dims;
    logic [31:0]        diff_sq;
    logic [23:0]        inv_var;
    logic [4:0]         lead_pos;
    logic [30:0]        mant;
    logic signed [31:0] norm_const;
    logic signed [31:0] log_weight;
  } item_t;

  // Truncated 16 fraction bits of log2(m) for m in Q.30 within [1,2).
  function automatic logic [15:0] log2_frac(input logic [63:0] m_in);
    logic [63:0] m;
    logic [15:0] bits;
    m    = m_in;
    bits = '0;
    for (int k = 0; k < LogFracBits; k++) begin
      m    = (m * m) >> 30;
      bits = {bits[14:0], 1'b0};
      if (m >= 64'h0000_0000_8000_0000) begin
        m       = m >> 1;
        bits[0] = 1'b1;
      end
    end
    return bits;
  endfunction

  // Non-negative log2 value in Q16.16 to natural log in Q16.16, rounded.
  function automatic logic [31:0] log2_to_ln_pos(input logic [63:0] l2);
    logic [63:0] prod;
    prod = l2 * {32'd0, Ln2Q32} + 64'h0000_0000_8000_0000;
    return prod[63:32];
  endfunction

  // One log-add table entry: ln(1 + exp(-d)) for d in Q16.16.
  function automatic logic [31:0] logadd_entry(input logic [63:0] d);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    logic [63:0] m;
    t  = d << 7;
    t2 = (t * t + HalfQ31) >> 31;
    t3 = (t2 * t + HalfQ31) >> 31;
    t4 = (t3 * t + HalfQ31) >> 31;
    e  = OneQ31 - t + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + HalfQ31) >> 31;
    end
    m = OneQ31 + e;
    if (m >= 64'h0000_0001_0000_0000) begin
      return log2_to_ln_pos(64'd65536);
    end
    return log2_to_ln_pos({48'd0, log2_frac(m >> 1)});
  endfunction

endpackage

// ===== design/gsll_front.sv =====
// ----------------------------------------------------------------------------
// gsll_front: input acceptance and item classification
// Takes one dimension per item, squares the feature difference, normalizes
// the inverse variance for the log unit, tracks the dimension count and
// tags each item with what the back end must do at its end.
// ----------------------------------------------------------------------------
module gsll_front #(
  parameter int MAX_DIMS = gsll_pkg::MaxDimsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    feature,
  input  logic signed [15:0]    mean,
  input  logic [23:0]           inv_var,
  input  logic signed [31:0]    norm_const,
  input  logic signed [31:0]    log_weight,
  input  logic                  last_dim,
  input  logic                  last_comp,
  output logic                  push_valid,
  input  logic                  push_ready,
  output gsll_pkg::item_t       push_item
);

  logic [gsll_pkg::DimW-1:0] dim_cnt_r;
  logic [gsll_pkg::DimW-1:0] dim_cnt_nxt;
  logic [gsll_pkg::DimW-1:0] dims_after;
  logic                      accept;
  logic                      acc;
  logic signed [16:0]        diff;
  logic signed [33:0]        diff_sq;
  logic [23:0]               v;
  logic [4:0]                lead;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;

  // Squared difference of feature and mean, at most 2^32 - 1.
  always_comb begin
    diff    = $signed({feature[15], feature}) - $signed({mean[15], mean});
    diff_sq = diff * diff;
  end

  // Leading one of the inverse variance; a zero code is read as one.
  always_comb begin
    v    = (inv_var == 24'd0) ? 24'd1 : inv_var;
    lead = 5'd0;
    for (int k = 0; k < 24; k++) begin
      if (v[k]) begin
        lead = 5'(k);
      end
    end
  end

  // Dimensions beyond the limit add nothing but still carry their markers.
  always_comb begin
    acc         = 32'(dim_cnt_r) < 32'(MAX_DIMS);
    dims_after  = acc ? dim_cnt_r + 1'b1 : dim_cnt_r;
    dim_cnt_nxt = dim_cnt_r;
    if (accept) begin
      dim_cnt_nxt = last_dim ? '0 : dims_after;
    end
  end

  // Build the queued item.
  always_comb begin
    push_item.acc        = acc;
    push_item.dims       = dims_after;
    push_item.diff_sq    = diff_sq[31:0];
    push_item.inv_var    = inv_var;
    push_item.lead_pos   = lead;
    push_item.mant       = {7'd0, v} << (5'd30 - lead);
    push_item.norm_const = norm_const;
    push_item.log_weight = log_weight;
    if (!last_dim) begin
      push_item.kind = gsll_pkg::KIND_DIM;
    end else if (last_comp) begin
      push_item.kind = gsll_pkg::KIND_STATE_END;
    end else begin
      push_item.kind = gsll_pkg::KIND_COMP_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_cnt_r <= '0;
    end else begin
      dim_cnt_r <= dim_cnt_nxt;
    end
  end

endmodule

// ===== design/gsll_fifo.sv =====
// ----------------------------------------------------------------------------
// gsll_fifo: item queue between front end and back end
// A short first-in first-out queue of classified items, so that the front
// end keeps accepting while the back end works through its steps.
// ----------------------------------------------------------------------------
module gsll_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  gsll_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output gsll_pkg::item_t pop_item
);

  localparam int Aw = (gsll_pkg::QueueDepth > 1) ? $clog2(gsll_pkg::QueueDepth) : 1;

  gsll_pkg::item_t slot_r [gsll_pkg::QueueDepth];
  logic [Aw-1:0]   wr_ptr_r;
  logic [Aw-1:0]   rd_ptr_r;
  logic [Aw:0]     count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count_r != (Aw + 1)'(gsll_pkg::QueueDepth);
  assign pop_valid  = count_r != '0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == gsll_pkg::QueueDepth - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == gsll_pkg::QueueDepth - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/gsll_back.sv =====
// ----------------------------------------------------------------------------
// gsll_back: accumulation, component scoring and log-add
// Works one queued item at a time: adds the weighted squared distance,
// computes ln(inv_var) by a 16-step squaring loop on one multiplier, and at
// a component end forms the score and merges it through the log-add table.
// ----------------------------------------------------------------------------
module gsll_back #(
  parameter int LOG_TABLE_ENTRIES = gsll_pkg::LogTableEntriesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  gsll_pkg::item_t    pop_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_data,
  output logic               out_floored
);

  localparam int IdxW    = $clog2(LOG_TABLE_ENTRIES);
  localparam int IdxMulW = 33 + IdxW + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM,
    S_LOG,
    S_LN,
    S_ACC,
    S_NORM,
    S_SUM,
    S_SCORE,
    S_LA_IDX,
    S_LA_ROM,
    S_LA_ADD,
    S_EMIT
  } state_t;

  state_t             state_r;
  gsll_pkg::item_t    item_r;
  logic [43:0]        term_r;
  logic [30:0]        m_r;
  logic [15:0]        bits_r;
  logic [3:0]         step_r;
  logic signed [53:0] prod_r;
  logic [47:0]        power_r;
  logic signed [39:0] log_acc_r;
  logic signed [41:0] norm_r;
  logic signed [49:0] sum_r;
  logic signed [31:0] score_r;
  logic signed [31:0] running_r;
  logic               have_r;
  logic signed [31:0] hi_r;
  logic [IdxW-1:0]    idx_r;
  logic               idx_ok_r;
  logic [31:0]        rom_q_r;
  logic signed [31:0] floor_r;
  logic               out_valid_r;
  logic signed [31:0] out_data_r;
  logic               out_floored_r;

  logic [31:0]        rom [LOG_TABLE_ENTRIES];

  logic [55:0]        term_full;
  logic [61:0]        m_sq;
  logic [31:0]        m_sq30;
  logic [30:0]        m_nxt;
  logic [4:0]         lead_m12;
  logic signed [20:0] l2;
  logic signed [53:0] prod_nxt;
  logic signed [53:0] ln_round;
  logic signed [39:0] log_acc_nxt;
  logic [48:0]        power_sum;
  logic [47:0]        power_nxt;
  logic [27:0]        dims_x;
  logic signed [41:0] norm_nxt;
  logic signed [49:0] sum_nxt;
  logic signed [50:0] neg_sum;
  logic signed [51:0] score_wide;
  logic signed [31:0] score_sat;
  logic signed [32:0] la_diff;
  logic [32:0]        la_abs;
  logic signed [31:0] la_hi;
  logic [IdxMulW-1:0] idx_full;
  logic               idx_ok;
  logic signed [32:0] la_sum;
  logic signed [31:0] la_sat;
  logic               last_step;
  logic               below_floor;

  // Log-add table, one entry per step of the 16.0 difference range.
  for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [63:0] DeltaQ16 =
      (64'(g) * gsll_pkg::LogaddRangeQ16) / 64'(LOG_TABLE_ENTRIES);
    assign rom[g] = gsll_pkg::logadd_entry(DeltaQ16);
  end

  assign pop_ready   = state_r == S_IDLE;
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign out_floored = out_floored_r;

  // Weighted squared distance, Q28.28 cut to Q16.16, and saturating sum.
  always_comb begin
    term_full = item_r.diff_sq * item_r.inv_var;
    power_sum = {1'b0, power_r} + {5'd0, term_r};
    power_nxt = power_sum[48] ? gsll_pkg::PowerMax : power_sum[47:0];
  end

  // One squaring step of the log2 fraction loop.
  always_comb begin
    m_sq      = m_r * m_r;
    m_sq30    = m_sq[61:30];
    m_nxt     = m_sq30[31] ? m_sq30[31:1] : m_sq30[30:0];
    last_step = step_r == 4'(gsll_pkg::LogFracBits - 1);
  end

  // log2 to natural log, rounded to nearest, and accumulation.
  always_comb begin
    lead_m12    = item_r.lead_pos - 5'd12;
    l2          = $signed({lead_m12, bits_r});
    prod_nxt    = l2 * $signed({1'b0, gsll_pkg::Ln2Q32});
    ln_round    = prod_r + 54'sh0000_8000_0000;
    log_acc_nxt = log_acc_r + {{18{ln_round[53]}}, ln_round[53:32]};
  end

  // Component normalizer, total and score.
  always_comb begin
    dims_x = item_r.dims * gsll_pkg::LogTwoPiQ16;
    if (item_r.norm_const == 32'sd0) begin
      norm_nxt = $signed({14'd0, dims_x}) - {{2{log_acc_r[39]}}, log_acc_r};
    end else begin
      norm_nxt = {{10{item_r.norm_const[31]}}, item_r.norm_const};
    end
    sum_nxt    = {{8{norm_r[41]}}, norm_r} + $signed({2'b00, power_r});
    neg_sum    = -{sum_r[49], sum_r};
    score_wide = {{2{neg_sum[50]}}, neg_sum[50:1]} + {{20{item_r.log_weight[31]}},
                                                      item_r.log_weight};
    if (score_wide > 52'sh0_0000_7FFF_FFFF) begin
      score_sat = 32'sh7FFF_FFFF;
    end else if (score_wide < -52'sh0_0000_8000_0000) begin
      score_sat = 32'sh8000_0000;
    end else begin
      score_sat = score_wide[31:0];
    end
  end

  // Log-add: larger value, table index from the difference, saturating sum.
  always_comb begin
    la_diff  = {running_r[31], running_r} - {score_r[31], score_r};
    la_hi    = la_diff[32] ? score_r : running_r;
    la_abs   = la_diff[32] ? -la_diff : la_diff;
    idx_full = (IdxMulW'(la_abs) * IdxMulW'(LOG_TABLE_ENTRIES)) >> gsll_pkg::LogaddShift;
    idx_ok   = idx_full < IdxMulW'(LOG_TABLE_ENTRIES);
    la_sum   = {hi_r[31], hi_r} + {1'b0, rom_q_r};
    la_sat   = (la_sum[32] != la_sum[31]) ? 32'sh7FFF_FFFF : la_sum[31:0];
  end

  assign below_floor = running_r < floor_r;

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      power_r     <= '0;
      log_acc_r   <= '0;
      running_r   <= '0;
      have_r      <= 1'b0;
      floor_r     <= 32'sh8000_0000;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        floor_r <= cfg_data;
      end
      // The emit step sets the valid flag itself.
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            item_r  <= pop_item;
            state_r <= S_TERM;
          end
        end
        S_TERM: begin
          term_r <= term_full[55:12];
          m_r    <= item_r.mant;
          bits_r <= '0;
          step_r <= '0;
          if (item_r.acc) begin
            state_r <= S_LOG;
          end else if (item_r.kind == gsll_pkg::KIND_DIM) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_LOG: begin
          m_r    <= m_nxt;
          bits_r <= {bits_r[14:0], m_sq30[31]};
          step_r <= step_r + 1'b1;
          if (last_step) begin
            state_r <= S_LN;
          end
        end
        S_LN: begin
          prod_r  <= prod_nxt;
          power_r <= power_nxt;
          state_r <= S_ACC;
        end
        S_ACC: begin
          log_acc_r <= log_acc_nxt;
          state_r   <= (item_r.kind == gsll_pkg::KIND_DIM) ? S_IDLE : S_NORM;
        end
        S_NORM: begin
          norm_r  <= norm_nxt;
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r     <= sum_nxt;
          power_r   <= '0;
          log_acc_r <= '0;
          state_r   <= S_SCORE;
        end
        S_SCORE: begin
          score_r <= score_sat;
          if (have_r) begin
            state_r <= S_LA_IDX;
          end else begin
            running_r <= score_sat;
            have_r    <= 1'b1;
            state_r   <= (item_r.kind == gsll_pkg::KIND_STATE_END) ? S_EMIT : S_IDLE;
          end
        end
        S_LA_IDX: begin
          hi_r     <= la_hi;
          idx_r    <= idx_full[IdxW-1:0];
          idx_ok_r <= idx_ok;
          state_r  <= S_LA_ROM;
        end
        S_LA_ROM: begin
          rom_q_r <= rom[idx_r];
          state_r <= S_LA_ADD;
        end
        S_LA_ADD: begin
          running_r <= idx_ok_r ? la_sat : hi_r;
          state_r   <= (item_r.kind == gsll_pkg::KIND_STATE_END) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          // Wait until the previous result has been taken.
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_data_r    <= below_floor ? floor_r : running_r;
            out_floored_r <= below_floor;
            running_r     <= '0;
            have_r        <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/gmm_state_log_likelihood.sv =====
// ----------------------------------------------------------------------------
// gmm_state_log_likelihood: diagonal Gaussian mixture score of one HMM state
// One input item carries one dimension of one mixture component; the total
// log likelihood of the state comes out after its last component.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one item per dimension; in_tlast marks the last dimension
//   of a component, and in_tuser set with it marks the last component.
//   Result stream: one item per state, the floored log likelihood in
//   out_tdata and a flag in out_tuser when the floor was applied.
//   Config channel: writes the floor value (Q16.16); it resets to -2^31.
// Sequencing:
//   A dimension item passes in the back end through the 16-step log2
//   squaring loop on its single multiplier, or only through the term step
//   past the dimension limit. A component end adds the normalizer, sum and
//   score steps, plus the index, table and add steps of the table log-add
//   from the second component on, and a state end adds the load of the
//   result register.
//   A two-entry queue lets the front end take items while the back end works.
// Reset clears the queue, all accumulators and the output valid flag. When
// the receiver stalls, the result holds in the output register and the back
// end waits at the next state end; input items queue until the queue fills.
// ----------------------------------------------------------------------------
module gmm_state_log_likelihood #(
  parameter int MAX_DIMS          = gsll_pkg::MaxDimsDefault,
  parameter int LOG_TABLE_ENTRIES = gsll_pkg::LogTableEntriesDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  // Fields from bit 0: feature[15:0], mean[31:16], inv_var[55:32],
  // norm_const[87:56], log_weight[119:88].
  input  logic [119:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tlast,
  // Fields from bit 0: last_component[0].
  input  logic         in_tuser,
  // Fields from bit 0: state_log_likelihood[31:0].
  output logic [31:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: floored[0].
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  logic               push_valid;
  logic               push_ready;
  gsll_pkg::item_t    push_item;
  logic               pop_valid;
  logic               pop_ready;
  gsll_pkg::item_t    pop_item;
  logic signed [31:0] out_data;

  // Input classification.
  gsll_front #(
    .MAX_DIMS (MAX_DIMS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .feature    ($signed(in_tdata[15:0])),
    .mean       ($signed(in_tdata[31:16])),
    .inv_var    (in_tdata[55:32]),
    .norm_const ($signed(in_tdata[87:56])),
    .log_weight ($signed(in_tdata[119:88])),
    .last_dim   (in_tlast),
    .last_comp  (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Item queue.
  gsll_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Scoring back end.
  gsll_back #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    ($signed(cfg_data)),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_data),
    .out_floored (out_tuser)
  );

  assign out_tdata = out_data;

endmodule

// ===== tb/gsll_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsll_checker: scoreboard for the GMM state log likelihood block
// Watches the input, result and floor-write channels, keeps its own model of
// the mixture scoring, and compares every result item field by field with the
// oldest predicted state total.
// ----------------------------------------------------------------------------
module gsll_checker #(
  parameter int MAX_DIMS          = 64,
  parameter int LOG_TABLE_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [119:0] in_tdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic         in_tlast,
  input  logic         in_tuser,
  input  logic [31:0]  out_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         drain,
  output int           fail_count,
  output int           pending,
  output int           results_seen,
  output int           floored_seen
);

  localparam longint LnTwoPiQ16  = 64'sd120447;
  localparam longint Ln2Q32      = 64'sd2977044472;
  localparam longint RoundHalf32 = 64'sd2147483648;
  localparam longint PowerCap    = 64'sd281474976710655;
  localparam longint LogaddSpan  = 64'sd1048576;
  localparam longint S32Max      = 64'sd2147483647;
  localparam longint S32Min      = -64'sd2147483648;
  localparam logic [63:0] OneQ31  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] HalfQ31 = 64'h0000_0000_4000_0000;

  // One predicted result item.
  typedef struct packed {
    logic [31:0] total;
    logic        floored;
  } state_total_t;

  state_total_t expected_totals[$];

  // Model state of the mixture scoring.
  longint floor_q16;
  longint power_sum;
  longint ln_invvar_sum;
  longint mix_log_sum;
  int     dims_seen;
  bit     mix_started;
  bit     drained;

  function automatic longint clamp_s32(input longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  // Sixteen truncated fraction bits of log2 of a Q.30 mantissa in [1,2).
  function automatic logic [15:0] log2_fraction(input logic [63:0] mant);
    logic [63:0] sq;
    logic [15:0] frac;
    sq   = mant;
    frac = 16'd0;
    for (int bit_pos = 15; bit_pos >= 0; bit_pos--) begin
      sq = (sq * sq) >> 30;
      if (sq >= OneQ31) begin
        sq = sq >> 1;
        frac[bit_pos] = 1'b1;
      end
    end
    return frac;
  endfunction

  // Q16.16 log2 to Q16.16 natural log, rounded to nearest with ties up.
  function automatic longint ln_from_log2(input longint l2);
    longint prod;
    prod = l2 * Ln2Q32 + RoundHalf32;
    return prod >>> 32;
  endfunction

  // Natural log of a Q12.12 inverse variance; zero is treated as one code.
  function automatic longint ln_of_invvar(input logic [23:0] ivar);
    logic [23:0] v;
    logic [63:0] mant;
    int          lead;
    longint      l2;
    v    = (ivar == 24'd0) ? 24'd1 : ivar;
    lead = 0;
    for (int b = 0; b < 24; b++) begin
      if (v[b]) lead = b;
    end
    mant = {40'd0, v} << (30 - lead);
    l2   = longint'(lead - 12) * 64'sd65536 + longint'({48'd0, log2_fraction(mant)});
    return ln_from_log2(l2);
  endfunction

  // exp(-d) in Q0.31 for a Q16.16 distance below 16.0: series on d/256,
  // then squared eight times.
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] d);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    t  = d << 7;
    t2 = (t * t + HalfQ31) >> 31;
    t3 = (t2 * t + HalfQ31) >> 31;
    t4 = (t3 * t + HalfQ31) >> 31;
    e  = OneQ31 - t + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
    repeat (8) e = (e * e + HalfQ31) >> 31;
    return e;
  endfunction

  // Table entry ln(1 + exp(-d)) at a given index.
  function automatic longint logadd_correction(input longint idx);
    logic [63:0] d;
    logic [63:0] m;
    d = 64'(idx) * 64'(LogaddSpan) / 64'(LOG_TABLE_ENTRIES);
    m = OneQ31 + exp_neg_q31(d);
    if (m >= 64'h0000_0001_0000_0000) return ln_from_log2(64'sd65536);
    return ln_from_log2(longint'({48'd0, log2_fraction(m >> 1)}));
  endfunction

  // Table-based log of the sum of exponentials of two Q16.16 scores.
  function automatic longint merge_log_sum(input longint a, input longint b);
    longint hi;
    longint gap;
    longint idx;
    hi  = (a > b) ? a : b;
    gap = (a > b) ? a - b : b - a;
    idx = (gap * LOG_TABLE_ENTRIES) / LogaddSpan;
    if (idx >= LOG_TABLE_ENTRIES) return hi;
    return clamp_s32(hi + logadd_correction(idx));
  endfunction

  // Advances the model by one accepted dimension item.
  task automatic score_dimension(input logic [119:0] data, input logic last_dim,
                                 input logic last_comp);
    longint       feat;
    longint       mu;
    longint       diff;
    longint       norm;
    longint       score;
    longint       total;
    logic [23:0]  ivar;
    state_total_t res;
    feat = longint'($signed(data[15:0]));
    mu   = longint'($signed(data[31:16]));
    ivar = data[55:32];

    // Dimensions past the limit add nothing but still carry the markers.
    if (dims_seen < MAX_DIMS) begin
      diff      = feat - mu;
      power_sum = power_sum + ((diff * diff * longint'({40'd0, ivar})) >>> 12);
      if (power_sum > PowerCap) power_sum = PowerCap;
      ln_invvar_sum = ln_invvar_sum + ln_of_invvar(ivar);
      dims_seen++;
    end
    if (!last_dim) return;

    // Component end: score it and merge it into the mixture sum.
    norm = longint'($signed(data[87:56]));
    if (norm == 0) norm = longint'(dims_seen) * LnTwoPiQ16 - ln_invvar_sum;
    score = (-(norm + power_sum)) >>> 1;
    score = clamp_s32(score + longint'($signed(data[119:88])));
    mix_log_sum   = mix_started ? merge_log_sum(mix_log_sum, score) : score;
    mix_started   = 1'b1;
    power_sum     = 0;
    ln_invvar_sum = 0;
    dims_seen     = 0;
    if (!last_comp) return;

    // State end: floor the total and expect one result item.
    total       = mix_log_sum;
    res.floored = 1'b0;
    if (total < floor_q16) begin
      total       = floor_q16;
      res.floored = 1'b1;
    end
    res.total = total[31:0];
    expected_totals.insert(expected_totals.size(), res);
    mix_log_sum = 0;
    mix_started = 1'b0;
  endtask

  always @(posedge clk) begin : watch_channels
    state_total_t want;
    if (!rst_n) begin
      floor_q16     = S32Min;
      power_sum     = 0;
      ln_invvar_sum = 0;
      mix_log_sum   = 0;
      dims_seen     = 0;
      mix_started   = 1'b0;
      drained       = 1'b0;
      expected_totals.delete();
    end else begin
      if (cfg_valid && cfg_ready) floor_q16 = longint'($signed(cfg_data));
      if (in_tvalid && in_tready) score_dimension(in_tdata, in_tlast, in_tuser);

      // Compare the result item with the oldest prediction.
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser) floored_seen++;
        if (expected_totals.size() == 0) begin
          $display("%0t: unexpected result item, total %h floored %b", $time,
                   out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expected_totals.pop_front();
          if (out_tdata !== want.total) begin
            $display("%0t: state total expected %h actual %h", $time, want.total,
                     out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.floored) begin
            $display("%0t: floored flag expected %b actual %b", $time, want.floored,
                     out_tuser);
            fail_count++;
          end
        end
      end

      // At the end of the run, anything still predicted never arrived.
      if (drain && !drained) begin
        drained = 1'b1;
        foreach (expected_totals[k]) begin
          $display("%0t: missing result item, expected total %h floored %b actual none",
                   $time, expected_totals[k].total, expected_totals[k].floored);
        end
        fail_count += expected_totals.size();
      end
    end
    pending = expected_totals.size();
  end

endmodule

// ===== tb/tb_gmm_state_log_likelihood.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gmm_state_log_likelihood: stimulus and verdict for the GMM state scorer
// Feeds directed edge cases and then random mixture states (typical, closely
// matched and full-range components, plus malformed runs) under several floor
// settings, with random idling on both streams, a long result stall and
// drain pauses. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_gmm_state_log_likelihood;

  localparam int MaxDims      = gsll_pkg::MaxDimsDefault;
  localparam int LogEntries   = gsll_pkg::LogTableEntriesDefault;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 120;
  localparam int LongHold     = 600;
  localparam int PhaseItems   = 200;
  localparam int PhaseCount   = 6;

  // How the fields of a random state are drawn.
  typedef enum int {
    STYLE_TYPICAL,
    STYLE_CLOSE,
    STYLE_WILD
  } draw_style_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic [119:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic         in_tlast;
  logic         in_tuser;
  logic [31:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;
  logic         drain;

  int fail_count;
  int pending;
  int results_seen;
  int floored_seen;

  int cycles = 0;
  int items_sent = 0;
  int states_sent = 0;
  int floor_writes = 0;
  int tx_gap_max = 13;
  int rx_gap_max = 13;
  bit rx_hold_req = 1'b0;

  gmm_state_log_likelihood #(
    .MAX_DIMS          (MaxDims),
    .LOG_TABLE_ENTRIES (LogEntries)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  gsll_checker #(
    .MAX_DIMS          (MaxDims),
    .LOG_TABLE_ENTRIES (LogEntries)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tlast     (in_tlast),
    .in_tuser     (in_tuser),
    .out_tdata    (out_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .drain        (drain),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .floored_seen (floored_seen)
  );

  always #2 clk = ~clk;

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("gmm_state_log_likelihood: mismatch");
      $finish;
    end
  end

  // Result receiver: random hold-off before each result item, and one long
  // stall when requested so the block backs up into its input.
  initial begin : receiver
    int hold;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        hold        = LongHold;
        rx_hold_req = 1'b0;
      end else begin
        hold = $urandom_range(0, rx_gap_max);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Random non-positive value in [-span, 0].
  function automatic logic [31:0] rand_nonpos(input logic [31:0] span);
    logic [31:0] x;
    x = $urandom_range(0, span);
    return 32'd0 - x;
  endfunction

  // Offers one dimension item after a random gap and waits until it is taken.
  // Called and returning at a falling edge; valid stays high on return.
  task automatic drive_item(input logic [15:0] feat, input logic [15:0] mean,
                            input logic [23:0] ivar, input logic [31:0] norm,
                            input logic [31:0] lw, input logic last_dim,
                            input logic last_comp);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {lw, norm, ivar, mean, feat};
    in_tlast  <= last_dim;
    in_tuser  <= last_comp;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // One well-formed state: a few components of a few dimensions each, with a
  // rare component longer than the dimension limit.
  task automatic send_state(input draw_style_t style);
    int          ncomp;
    int          ndims;
    int          mean_i;
    int          feat_i;
    logic [23:0] ivar;
    logic [31:0] shared_norm;
    logic [31:0] comp_norm;
    logic [31:0] comp_lw;
    logic        last_dim;
    shared_norm = $urandom_range(1, 20 << 16);
    ncomp = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    for (int c = 0; c < ncomp; c++) begin
      ndims = ($urandom_range(0, 39) == 0) ? $urandom_range(MaxDims + 1, MaxDims + 4)
                                           : $urandom_range(1, 5);
      case (style)
        STYLE_TYPICAL: begin
          comp_norm = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 80 << 16))
                                                   - 32'(40 << 16);
          comp_lw   = rand_nonpos(8 << 16);
        end
        STYLE_CLOSE: begin
          comp_norm = shared_norm;
          comp_lw   = rand_nonpos(12 << 16);
        end
        default: begin
          comp_norm = $urandom;
          comp_lw   = rand_nonpos(32'h8000_0000);
        end
      endcase
      for (int d = 0; d < ndims; d++) begin
        case (style)
          STYLE_TYPICAL: begin
            mean_i = int'($urandom_range(0, 4096)) - 2048;
            feat_i = mean_i + int'($urandom_range(0, 1024)) - 512;
            ivar   = 24'($urandom_range(256, 65535));
          end
          STYLE_CLOSE: begin
            mean_i = int'($urandom_range(0, 4096)) - 2048;
            feat_i = mean_i + int'($urandom_range(0, 128)) - 64;
            ivar   = 24'h001000;
          end
          default: begin
            mean_i = $urandom;
            feat_i = $urandom;
            ivar   = 24'($urandom);
          end
        endcase
        last_dim = (d == ndims - 1);
        // Norm and weight only matter at the last dimension; elsewhere noise.
        if (last_dim) begin
          drive_item(feat_i[15:0], mean_i[15:0], ivar, comp_norm, comp_lw, 1'b1,
                     c == ncomp - 1);
        end else begin
          drive_item(feat_i[15:0], mean_i[15:0], ivar, $urandom, $urandom, 1'b0,
                     1'($urandom_range(0, 1)));
        end
      end
    end
    states_sent++;
  endtask

  // Malformed run: random markers on full-range or typical fields.
  task automatic send_noise(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1)) begin
        drive_item(16'($urandom), 16'($urandom), 24'($urandom), $urandom,
                   rand_nonpos(32'h8000_0000), $urandom_range(0, 2) == 0,
                   1'($urandom_range(0, 1)));
      end else begin
        drive_item(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                   24'($urandom_range(1, 8192)), $urandom_range(0, 1) ? 32'd0 : $urandom,
                   rand_nonpos(4 << 16), $urandom_range(0, 2) == 0,
                   1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Writes the floor once the block has drained and settled.
  task automatic write_floor(input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    floor_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase_start;
    int          pick;
    logic [31:0] floor_val;
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    drain     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes under the reset floor.
    drive_item(16'h7FFF, 16'h8000, 24'hFFFFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    drive_item(16'h8000, 16'h7FFF, 24'h000001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    // Zero inverse variance inside a computed-norm component.
    drive_item(16'h0100, 16'h0000, 24'h000000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    drive_item(16'h0080, 16'h0100, 24'h001000, 32'h0000_0000, 32'hFFFF_0000, 1'b1, 1'b1);
    // Last component flag without the last dimension is ignored.
    drive_item(16'h0000, 16'h0000, 24'h001000, 32'h0001_2345, 32'hFFFF_FFFF, 1'b0, 1'b1);
    drive_item(16'h0040, 16'h0000, 24'h002000, 32'h0000_0000, 32'hFFFE_0000, 1'b1, 1'b0);
    drive_item(16'h0000, 16'h0010, 24'h000800, 32'h0002_0000, 32'h0000_0000, 1'b1, 1'b1);
    // Identical components: log-add at zero distance.
    drive_item(16'h0100, 16'h0080, 24'h001000, 32'h0001_0000, 32'hFFFF_8000, 1'b1, 1'b0);
    drive_item(16'h0100, 16'h0080, 24'h001000, 32'h0001_0000, 32'hFFFF_8000, 1'b1, 1'b1);
    // Distance exactly at the table range, then one code inside it.
    drive_item(16'h0000, 16'h0000, 24'h001000, 32'h0000_0002, 32'h0000_0000, 1'b1, 1'b0);
    drive_item(16'h0000, 16'h0000, 24'h001000, 32'h0000_0002, 32'hFFF0_0000, 1'b1, 1'b1);
    drive_item(16'h0000, 16'h0000, 24'h001000, 32'h0000_0002, 32'h0000_0000, 1'b1, 1'b0);
    drive_item(16'h0000, 16'h0000, 24'h001000, 32'h0000_0002, 32'hFFF0_0001, 1'b1, 1'b1);
    // Largest positive component scores.
    drive_item(16'h0000, 16'h0000, 24'h001000, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
    drive_item(16'h0000, 16'h0000, 24'h001000, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1);

    // Random phases, each under its own floor and idling pattern.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       floor_val = 32'h0000_0000;
        1:       floor_val = 32'h8000_0000;
        2:       floor_val = 32'd0 - 32'(30 << 16);
        3:       floor_val = 32'(2 << 16);
        4:       floor_val = 32'd0 - 32'(6 << 16);
        default: floor_val = rand_nonpos(32'h8000_0000);
      endcase
      write_floor(floor_val);
      tx_gap_max = (ph == 1 || ph == 2 || ph == 4) ? 0 : 13;
      rx_gap_max = (ph == 1 || ph == 4) ? 0 : 13;
      if (ph == 2) rx_hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) send_noise($urandom_range(1, 6));
        else if (pick <= 4) send_state(STYLE_TYPICAL);
        else if (pick <= 7) send_state(STYLE_CLOSE);
        else send_state(STYLE_WILD);
        // In this phase the sender drains the block after every state.
        if (ph == 3) begin
          in_tvalid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
      end
    end

    // Drain, let the block settle, then collect the verdict.
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    drain <= 1'b1;
    repeat (2) @(negedge clk);
    $display("Sent %0d items: %0d well-formed states plus malformed runs, %0d floor writes.",
             items_sent, states_sent, floor_writes);
    $display("Checked %0d state totals, %0d of them raised to the floor.", results_seen,
             floored_seen);
    if (fail_count == 0) begin
      $display("gmm_state_log_likelihood: match");
    end else begin
      $display("gmm_state_log_likelihood: mismatch");
    end
    $finish;
  end

endmodule
